// File: src/qtwc_pkg.sv
// Shared types, constants and codes of the query timestamp window check.
package qtwc_pkg;

   // Width of the parsed timestamp value; larger values are unparsable
   localparam int VALUE_BITS = 63;
   localparam int NOW_BITS = 42;
   localparam int WINDOW_BITS = 31;
   localparam int BOUND_BITS = NOW_BITS + 1;
   localparam int SUM_BITS = VALUE_BITS + 4;
   localparam int CMP_BITS = (VALUE_BITS > BOUND_BITS) ? VALUE_BITS : BOUND_BITS;

   // Key "timestamp=" and separator characters
   localparam int KEY_LEN = 10;
   localparam int KPOS_BITS = $clog2(KEY_LEN + 1);
   localparam int KHIT_LEN = 2 ** KPOS_BITS;
   localparam logic [7:0] KEY_CHARS [KEY_LEN] = '{
      8'h74, 8'h69, 8'h6d, 8'h65, 8'h73, 8'h74, 8'h61, 8'h6d, 8'h70, 8'h3d
   };
   localparam logic [7:0] AMP_CHAR = 8'h26;
   localparam logic [7:0] DIGIT_LO = 8'h30;
   localparam logic [7:0] DIGIT_HI = 8'h39;

   // Configuration registers
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(60 * 3);
   localparam logic REG_CHECK_ENABLE = 1'b0;
   localparam logic REG_WINDOW_SECONDS = 1'b1;

   // Queue between classifier and scanner
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [SUM_BITS-1:0] sum_type;
   typedef logic [CMP_BITS-1:0] cmp_type;
   typedef logic [KPOS_BITS-1:0] kpos_type;
   typedef logic [QPTR_BITS-1:0] qptr_type;
   typedef logic [QCNT_BITS-1:0] qcnt_type;

   typedef enum logic [1:0] {
      PH_KEY   = 2'd0,
      PH_SKIP  = 2'd1,
      PH_VALUE = 2'd2
   } scan_phase_type;

   typedef enum logic [2:0] {
      CAUSE_WITHIN   = 3'd0,
      CAUSE_DISABLED = 3'd1,
      CAUSE_MISSING  = 3'd2,
      CAUSE_ABOVE    = 3'd3,
      CAUSE_BELOW    = 3'd4
   } cause_type;

   // Live configuration
   typedef struct packed {
      logic                   check_enable;
      logic [WINDOW_BITS-1:0] window_seconds;
   } csr_cfg_type;

   // One classified item as it travels through the queue
   typedef struct packed {
      logic                  is_end;
      logic                  is_amp;
      logic                  is_digit;
      logic [3:0]            digit;
      logic [KHIT_LEN-1:0]   key_hit;
      logic [BOUND_BITS-1:0] upper;
      logic [NOW_BITS-1:0]   lower;
      logic                  lower_ok;
   } item_type;

endpackage

// File: src/qtwc_csr.sv
// Configuration register block with an APB-style access port.
module qtwc_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output qtwc_pkg::csr_cfg_type cfg
);

   logic                                 enable_ff, enable_in;
   logic [qtwc_pkg::WINDOW_BITS-1:0]     window_ff, window_in;
   logic                                 wr_en;
   logic                                 reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Decode writes
   always_comb begin
      enable_in = enable_ff;
      window_in = window_ff;
      if (wr_en) begin
         unique case (reg_idx)
            qtwc_pkg::REG_CHECK_ENABLE:   enable_in = csr_pwdata[0];
            qtwc_pkg::REG_WINDOW_SECONDS: window_in = csr_pwdata[qtwc_pkg::WINDOW_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         window_ff <= qtwc_pkg::WINDOW_RESET;
      end else begin
         enable_ff <= enable_in;
         window_ff <= window_in;
      end
   end

   // Return register contents on reads
   always_comb begin
      unique case (reg_idx)
         qtwc_pkg::REG_CHECK_ENABLE:   csr_prdata = {31'b0, enable_ff};
         qtwc_pkg::REG_WINDOW_SECONDS: csr_prdata = {1'b0, window_ff};
         default:                      csr_prdata = 32'b0;
      endcase
   end

   assign cfg.check_enable = enable_ff;
   assign cfg.window_seconds = window_ff;

endmodule

// File: src/qtwc_front.sv
// Input stage: accepts beats, classifies query bytes and precomputes time bounds.
module qtwc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [55:0]           req_tdata,
   input  logic                  req_tlast,
   input  qtwc_pkg::csr_cfg_type cfg,
   output logic                  push,
   output qtwc_pkg::item_type    push_item,
   input  logic                  queue_full
);

   logic                                valid_ff, valid_in;
   qtwc_pkg::item_type                  item_ff, item_in;
   logic [7:0]                          byte_val;
   logic [qtwc_pkg::NOW_BITS-1:0]       now_val;
   logic [qtwc_pkg::BOUND_BITS-1:0]     diff;
   logic                                take;

   assign byte_val = req_tdata[7:0];
   assign now_val = req_tdata[49:8];

   // Advance whenever the held beat can move into the queue
   assign push = valid_ff && !queue_full;
   assign req_tready = !valid_ff || !queue_full;
   assign take = req_tvalid && req_tready;
   assign push_item = item_ff;

   // Classify the byte and form now+window and now-window
   always_comb begin
      item_in = '0;
      item_in.is_end = req_tlast;
      item_in.is_amp = (byte_val == qtwc_pkg::AMP_CHAR);
      item_in.is_digit = (byte_val >= qtwc_pkg::DIGIT_LO) && (byte_val <= qtwc_pkg::DIGIT_HI);
      item_in.digit = byte_val[3:0];
      for (int k = 0; k < qtwc_pkg::KEY_LEN; k++) begin
         item_in.key_hit[k] = (byte_val == qtwc_pkg::KEY_CHARS[k]);
      end
      diff = {1'b0, now_val} - qtwc_pkg::BOUND_BITS'(cfg.window_seconds);
      item_in.upper = {1'b0, now_val} + qtwc_pkg::BOUND_BITS'(cfg.window_seconds);
      item_in.lower = diff[qtwc_pkg::NOW_BITS-1:0];
      item_in.lower_ok = !diff[qtwc_pkg::BOUND_BITS-1];
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload until taken by the queue
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: src/qtwc_queue.sv
// Short queue of classified items between the classifier and the scanner.
module qtwc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  qtwc_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output qtwc_pkg::item_type pop_item
);

   qtwc_pkg::item_type  entry_ff [qtwc_pkg::QUEUE_DEPTH];
   qtwc_pkg::qptr_type  wr_ptr_ff, wr_ptr_in;
   qtwc_pkg::qptr_type  rd_ptr_ff, rd_ptr_in;
   qtwc_pkg::qcnt_type  count_ff, count_in;

   assign full = (count_ff == qtwc_pkg::qcnt_type'(qtwc_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + qtwc_pkg::qptr_type'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + qtwc_pkg::qptr_type'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + qtwc_pkg::qcnt_type'(1);
      end else if (pop && !push) begin
         count_in = count_ff - qtwc_pkg::qcnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: src/qtwc_back.sv
// Scanner: tracks the timestamp parameter, parses its value and registers the verdict.
module qtwc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  qtwc_pkg::csr_cfg_type cfg,
   input  logic                  q_valid,
   input  qtwc_pkg::item_type    q_item,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata
);

   qtwc_pkg::scan_phase_type phase_ff, phase_in;
   qtwc_pkg::kpos_type       kpos_ff, kpos_in;
   qtwc_pkg::value_type      cand_value_ff, cand_value_in;
   logic                     cand_digit_ff, cand_digit_in;
   logic                     cand_bad_ff, cand_bad_in;
   qtwc_pkg::value_type      comm_value_ff, comm_value_in;
   logic                     comm_valid_ff, comm_valid_in;
   logic                     comm_found_ff, comm_found_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_forbid_ff, rsp_forbid_in;
   qtwc_pkg::cause_type      rsp_cause_ff, rsp_cause_in;

   logic                     out_free;
   logic                     in_value;
   logic                     key_match;
   logic                     overflow;
   qtwc_pkg::sum_type        next_sum;
   qtwc_pkg::value_type      eff_value;
   logic                     eff_valid;
   logic                     eff_found;
   qtwc_pkg::cmp_type        cmp_value;
   qtwc_pkg::cmp_type        cmp_upper;
   qtwc_pkg::cmp_type        cmp_lower;
   qtwc_pkg::cause_type      cause;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign pop = q_valid && (!q_item.is_end || out_free);
   assign in_value = (phase_ff == qtwc_pkg::PH_VALUE);

   // Key character and decimal step
   assign key_match = (kpos_ff < qtwc_pkg::kpos_type'(qtwc_pkg::KEY_LEN)) &&
                      q_item.key_hit[kpos_ff];
   assign next_sum = (qtwc_pkg::sum_type'(cand_value_ff) << 3) +
                     (qtwc_pkg::sum_type'(cand_value_ff) << 1) +
                     qtwc_pkg::sum_type'(q_item.digit);
   assign overflow = |next_sum[qtwc_pkg::SUM_BITS-1:qtwc_pkg::VALUE_BITS];

   // Close an open value parameter at end of query
   assign eff_found = comm_found_ff || in_value;
   assign eff_valid = in_value ? (cand_digit_ff && !cand_bad_ff) : comm_valid_ff;
   assign eff_value = in_value ? cand_value_ff : comm_value_ff;
   assign cmp_value = qtwc_pkg::cmp_type'(eff_value);
   assign cmp_upper = qtwc_pkg::cmp_type'(q_item.upper);
   assign cmp_lower = qtwc_pkg::cmp_type'(q_item.lower);

   // Verdict
   always_comb begin
      priority if (!cfg.check_enable) begin
         cause = qtwc_pkg::CAUSE_DISABLED;
      end else if (!eff_found || !eff_valid) begin
         cause = qtwc_pkg::CAUSE_MISSING;
      end else if (cmp_value > cmp_upper) begin
         cause = qtwc_pkg::CAUSE_ABOVE;
      end else if (q_item.lower_ok && (cmp_value < cmp_lower)) begin
         cause = qtwc_pkg::CAUSE_BELOW;
      end else begin
         cause = qtwc_pkg::CAUSE_WITHIN;
      end
   end

   // Scan state update
   always_comb begin
      phase_in = phase_ff;
      kpos_in = kpos_ff;
      cand_value_in = cand_value_ff;
      cand_digit_in = cand_digit_ff;
      cand_bad_in = cand_bad_ff;
      comm_value_in = comm_value_ff;
      comm_valid_in = comm_valid_ff;
      comm_found_in = comm_found_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_forbid_in = rsp_forbid_ff;
      rsp_cause_in = rsp_cause_ff;

      if (pop) begin
         if (q_item.is_end || q_item.is_amp) begin
            // Commit a finished timestamp parameter, then restart the scan
            if (in_value) begin
               comm_found_in = 1'b1;
               comm_valid_in = cand_digit_ff && !cand_bad_ff;
               comm_value_in = cand_value_ff;
            end
            phase_in = qtwc_pkg::PH_KEY;
            kpos_in = '0;
            cand_value_in = '0;
            cand_digit_in = 1'b0;
            cand_bad_in = 1'b0;
            if (q_item.is_end) begin
               // Drop all query state and issue the verdict
               comm_found_in = 1'b0;
               comm_valid_in = 1'b0;
               comm_value_in = '0;
               rsp_valid_in = 1'b1;
               rsp_cause_in = cause;
               rsp_forbid_in = (cause != qtwc_pkg::CAUSE_WITHIN) &&
                               (cause != qtwc_pkg::CAUSE_DISABLED);
            end
         end else begin
            unique case (phase_ff)
               qtwc_pkg::PH_KEY: begin
                  if (key_match) begin
                     kpos_in = kpos_ff + qtwc_pkg::kpos_type'(1);
                     if (kpos_in == qtwc_pkg::kpos_type'(qtwc_pkg::KEY_LEN)) begin
                        phase_in = qtwc_pkg::PH_VALUE;
                        cand_value_in = '0;
                        cand_digit_in = 1'b0;
                        cand_bad_in = 1'b0;
                     end
                  end else begin
                     phase_in = qtwc_pkg::PH_SKIP;
                  end
               end
               qtwc_pkg::PH_VALUE: begin
                  if (!cand_bad_ff) begin
                     if (!q_item.is_digit || overflow) begin
                        cand_bad_in = 1'b1;
                     end else begin
                        cand_value_in = next_sum[qtwc_pkg::VALUE_BITS-1:0];
                        cand_digit_in = 1'b1;
                     end
                  end
               end
               qtwc_pkg::PH_SKIP: ;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= qtwc_pkg::PH_KEY;
         kpos_ff <= '0;
         cand_value_ff <= '0;
         cand_digit_ff <= 1'b0;
         cand_bad_ff <= 1'b0;
         comm_value_ff <= '0;
         comm_valid_ff <= 1'b0;
         comm_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         kpos_ff <= kpos_in;
         cand_value_ff <= cand_value_in;
         cand_digit_ff <= cand_digit_in;
         cand_bad_ff <= cand_bad_in;
         comm_value_ff <= comm_value_in;
         comm_valid_ff <= comm_valid_in;
         comm_found_ff <= comm_found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      rsp_forbid_ff <= rsp_forbid_in;
      rsp_cause_ff <= rsp_cause_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'b0, rsp_cause_ff, rsp_forbid_ff};

`ifndef SYNTHESIS
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && q_item.is_end) |=> (phase_ff == qtwc_pkg::PH_KEY) && !comm_found_ff &&
                                 (kpos_ff == '0))
      else $error("query state not cleared after end beat");
   a_key_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == qtwc_pkg::PH_KEY) |-> (kpos_ff < qtwc_pkg::kpos_type'(qtwc_pkg::KEY_LEN)))
      else $error("key position past key length while matching");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_cause_ff) && $stable(rsp_forbid_ff))
      else $error("pending verdict overwritten");
   a_value_has_key: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == qtwc_pkg::PH_VALUE) |-> (kpos_ff == qtwc_pkg::kpos_type'(qtwc_pkg::KEY_LEN)))
      else $error("value phase entered without full key");
`endif

endmodule

// File: src/query_timestamp_window_check_unit.sv
// An end beat's verdict passes the front holding register, the queue and the response register.
// Throughput: one beat per cycle; the scanner retires one queued item per cycle, unless stalled.
// The 4-entry queue between classifier and scanner absorbs rsp_tready stalls.
// Reset (synchronous, active high) empties the pipeline, clears the scan state,
// disables the check and sets the window to 180 seconds.
module query_timestamp_window_check_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // query_byte [7:0], now_seconds [49:8], zero [55:50]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // forbid [0], cause [3:1], zero [7:4]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   qtwc_pkg::csr_cfg_type cfg;
   logic                  push;
   qtwc_pkg::item_type    push_item;
   logic                  queue_full;
   logic                  pop;
   logic                  pop_valid;
   qtwc_pkg::item_type    pop_item;

   qtwc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   qtwc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cfg        (cfg),
      .push       (push),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   qtwc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   qtwc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (pop_valid),
      .q_item     (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
